// File: sv/assert_macros.svh
// Assertion helpers shared by the color matrix pipeline.
// Every user names its clock clk and its reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define CMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define CMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cmc_pkg.sv
package cmc_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 14;
    // Three integer bits including sign: inverse YUV needs 2.02
    localparam int COEF_W = COEF_FRAC_BITS + 3;
    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Y_W    = ACC_W - COEF_FRAC_BITS;
    localparam int Q30_SH = 30 - COEF_FRAC_BITS;

    localparam int IDX_W  = 2;
    localparam int DATA_W = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MATRIX_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_DIRECTION   = 2'd1;

    // Reset codes
    localparam logic [1:0] MODE_IDENTITY = 2'd0;
    localparam logic       DIR_FORWARD   = 1'b0;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ACC_W-1:0]        acc_t;

    typedef sample_t sample_vec_t [3];
    typedef coef_t   coef_mat_t [3][3];
    typedef prod_t   prod_mat_t [3][3];
    typedef acc_t    acc_vec_t [3];

    localparam acc_t ROUND_BIAS = acc_t'(1) <<< (COEF_FRAC_BITS - 1);

    // Exact Q.30 coefficients, row-major, indexed by {mode, direction}
    localparam longint Q30_TBL [8][9] = '{
        // identity forward / inverse
        '{1073741824, 0, 0, 0, 1073741824, 0, 0, 0, 1073741824},
        '{1073741824, 0, 0, 0, 1073741824, 0, 0, 0, 1073741824},
        // opponent forward / inverse
        '{357913941, 357913941, 357913941,
          536870912, 0, -536870912,
          268435456, -536870912, 268435456},
        '{1073741824, 1073741824, 715827883,
          1073741824, 0, -1431655765,
          1073741824, -1073741824, 715827883},
        // YUV forward / inverse
        '{322122547, 633507676, 118111601,
          -161061274, -311385129, 472446403,
          654982513, -547608330, -107374182},
        '{1073741824, 12288284, 1235184458,
          1073741824, -411445663, -629244913,
          1073741824, 64'sd2173331419, 6356009},
        // YCbCr forward / inverse
        '{322122547, 633507676, 118111601,
          -182536110, -354334802, 536870912,
          536870912, -450971566, -85899346},
        '{1073741824, 4542055, 1504782852,
          1073741824, -358822352, -766244694,
          1073741824, 1912205194, 5904672}
    };

    // Round a Q.30 constant to COEF_FRAC_BITS fraction bits, half away from zero
    function automatic coef_t coef_round(input longint q);
        logic   neg;
        longint mag;
        neg = (q < 0);
        mag = neg ? -q : q;
        mag = (mag + (longint'(1) << (Q30_SH - 1))) >>> Q30_SH;
        return coef_t'(neg ? -mag : mag);
    endfunction

    // Coefficient matrix for the selected set and direction
    function automatic coef_mat_t coef_lookup(input logic [1:0] mode, input logic dir);
        coef_mat_t m;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m[r][k] = coef_round(Q30_TBL[{mode, dir}][r*3+k]);
            end
        end
        return m;
    endfunction

endpackage

// File: sv/cmc_mult.sv
`include "assert_macros.svh"

module cmc_mult (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cmc_pkg::sample_vec_t x_in,
    input  cmc_pkg::coef_mat_t coef_in,
    input  logic               down_en,
    output logic               up_en,
    output logic               prod_valid,
    output cmc_pkg::prod_mat_t prod
);
    import cmc_pkg::*;

    sample_vec_t x_reg;
    coef_mat_t   coef_reg;
    logic        v1_reg;
    logic        v1_next;
    prod_mat_t   prod_reg;
    prod_mat_t   prod_next;
    logic        v2_reg;
    logic        v2_next;
    logic        en1;
    logic        en2;

    // Advance a stage when it is empty or its successor advances
    assign en2   = !v2_reg || down_en;
    assign en1   = !v1_reg || en2;
    assign up_en = en1;

    assign v1_next = en1 ? in_valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;

    // Nine products, full precision
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[r][k] = prod_t'(x_reg[k]) * prod_t'(coef_reg[r][k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Capture samples with their coefficients, then the products
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x_reg    <= x_in;
            coef_reg <= coef_in;
        end
        if (en2)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = v2_reg;
    assign prod       = prod_reg;

    `CMC_ASSERT_NEXT(a_mult_forward, v1_reg && down_en, v2_reg, "mult: product stage lost a transaction")

endmodule

// File: sv/cmc_accum.sv
`include "assert_macros.svh"

module cmc_accum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               prod_valid,
    input  cmc_pkg::prod_mat_t prod,
    input  logic               down_en,
    output logic               up_en,
    output logic               acc_valid,
    output cmc_pkg::acc_vec_t  acc
);
    import cmc_pkg::*;

    acc_vec_t acc_reg;
    acc_vec_t acc_next;
    logic     v3_reg;
    logic     v3_next;
    logic     en3;

    assign en3     = !v3_reg || down_en;
    assign up_en   = en3;
    assign v3_next = en3 ? prod_valid : v3_reg;

    // Sum each row and add the rounding half
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = acc_t'(prod[r][0]) + acc_t'(prod[r][1])
                        + acc_t'(prod[r][2]) + ROUND_BIAS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_valid = v3_reg;
    assign acc       = acc_reg;

    `CMC_ASSERT_NEXT(a_accum_fill, prod_valid && !v3_reg, v3_reg, "accum: empty stage did not take a transaction")

endmodule

// File: sv/cmc_sat.sv
`include "assert_macros.svh"

module cmc_sat (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc_valid,
    input  cmc_pkg::acc_vec_t acc,
    input  logic              out_stall,
    output logic              up_en,
    output logic              out_valid,
    output cmc_pkg::sample_t  chan_a_out,
    output cmc_pkg::sample_t  chan_b_out,
    output cmc_pkg::sample_t  chan_c_out,
    output logic              clipped
);
    import cmc_pkg::*;

    localparam sample_t SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    sample_vec_t y_reg;
    sample_vec_t y_next;
    logic        clip_reg;
    logic        clip_next;
    logic        v4_reg;
    logic        v4_next;
    logic        en4;

    assign en4     = !v4_reg || !out_stall;
    assign up_en   = en4;
    assign v4_next = en4 ? acc_valid : v4_reg;

    // Drop the fraction bits, then clamp to the sample range
    always_comb
    begin
        logic [Y_W-1:0]            y;
        logic [Y_W-SAMPLE_WIDTH:0] hi;
        clip_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            y  = acc[r][ACC_W-1:COEF_FRAC_BITS];
            hi = y[Y_W-1:SAMPLE_WIDTH-1];
            if ((&hi) || !(|hi))
            begin
                y_next[r] = sample_t'(y[SAMPLE_WIDTH-1:0]);
            end
            else
            begin
                y_next[r] = y[Y_W-1] ? SMIN : SMAX;
                clip_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            y_reg    <= y_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid  = v4_reg;
    assign chan_a_out = y_reg[0];
    assign chan_b_out = y_reg[1];
    assign chan_c_out = y_reg[2];
    assign clipped    = clip_reg;

    `CMC_ASSERT_IMP(a_clip_bound, v4_reg && clip_reg, y_reg[0] == SMAX || y_reg[0] == SMIN || y_reg[1] == SMAX || y_reg[1] == SMIN || y_reg[2] == SMAX || y_reg[2] == SMIN, "sat: clipped set with no channel at a bound")

endmodule

// File: sv/color_matrix_convert_unit.sv
// Color matrix converter: one pixel of three signed Q3.12 samples in, three
// converted samples plus a saturation flag out, through a 3x3 matrix.
// Input channel: in_valid / in_stall with chan_a_in, chan_b_in, chan_c_in.
// Output channel: out_valid / out_stall with chan_a_out, chan_b_out,
// chan_c_out and clipped. A transaction moves when valid is high and stall
// is low.
// Configuration: wr_en, wr_index, wr_data; index 0 selects the coefficient
// set (identity, opponent, YUV, YCbCr), index 1 the direction (forward or
// inverse). Write only while the pipeline is empty.
// Pipeline: four register stages (capture, multiply, sum, round and clamp);
// a pixel passes them in order. Throughput: one pixel per cycle while
// out_stall is low, set by the fully pipelined multipliers.
// Reset clears all valid bits and selects identity, forward.
// When the receiver stalls, the output holds; stages behind it keep filling
// bubbles and in_stall rises only once every stage is full.
`include "assert_macros.svh"

module color_matrix_convert_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [cmc_pkg::IDX_W-1:0]   wr_index,
    input  logic [cmc_pkg::DATA_W-1:0]  wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cmc_pkg::sample_t            chan_a_in,
    input  cmc_pkg::sample_t            chan_b_in,
    input  cmc_pkg::sample_t            chan_c_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cmc_pkg::sample_t            chan_a_out,
    output cmc_pkg::sample_t            chan_b_out,
    output cmc_pkg::sample_t            chan_c_out,
    output logic                        clipped
);
    import cmc_pkg::*;

    logic [1:0]  matrix_mode_reg;
    logic [1:0]  matrix_mode_next;
    logic        direction_reg;
    logic        direction_next;
    coef_mat_t   coef_sel;
    sample_vec_t x_in;
    logic        en1;
    logic        en3;
    logic        en4;
    logic        prod_valid;
    prod_mat_t   prod;
    logic        acc_valid;
    acc_vec_t    acc;

    // Decode configuration writes; other indexes do nothing
    always_comb
    begin
        matrix_mode_next = matrix_mode_reg;
        direction_next   = direction_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MATRIX_MODE: matrix_mode_next = wr_data[1:0];
                REG_DIRECTION:   direction_next   = wr_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_mode_reg <= MODE_IDENTITY;
            direction_reg   <= DIR_FORWARD;
        end
        else
        begin
            matrix_mode_reg <= matrix_mode_next;
            direction_reg   <= direction_next;
        end
    end

    assign coef_sel = coef_lookup(matrix_mode_reg, direction_reg);
    assign x_in[0]  = chan_a_in;
    assign x_in[1]  = chan_b_in;
    assign x_in[2]  = chan_c_in;
    assign in_stall = !en1;

    cmc_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .x_in       (x_in),
        .coef_in    (coef_sel),
        .down_en    (en3),
        .up_en      (en1),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    cmc_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .down_en    (en4),
        .up_en      (en3),
        .acc_valid  (acc_valid),
        .acc        (acc)
    );

    cmc_sat u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_valid  (acc_valid),
        .acc        (acc),
        .out_stall  (out_stall),
        .up_en      (en4),
        .out_valid  (out_valid),
        .chan_a_out (chan_a_out),
        .chan_b_out (chan_b_out),
        .chan_c_out (chan_c_out),
        .clipped    (clipped)
    );

    `CMC_ASSERT_IMP(a_stall_full, in_stall, prod_valid && acc_valid && out_valid, "top: input stalled with a bubble in the pipeline")

endmodule
